// File: rtl/core/eed_pkg.sv
// Shared constants, state encoding and control structs for the extended Euclid solver.
`timescale 1ns / 1ps

package eed_pkg;

	localparam int OPERAND_W_DEF = 32;
	localparam int FIELD_W       = 32;
	localparam int SOL_W         = 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_REDUCE,
		ST_MUL_X,
		ST_MUL_Y
	} eed_state_t;

	typedef struct packed {
		logic load;
		logic align;
		logic reduce;
	} eed_ctrl_t;

	typedef struct packed {
		logic special;
		logic can_align;
		logic k_zero;
		logic rem_zero;
	} eed_stat_t;

	typedef struct packed {
		logic mul_x;
		logic commit;
	} eed_mul_ctrl_t;

endpackage

// File: rtl/core/eed_if.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps

interface eed_req_if;
	logic                                valid;
	logic                                ready;
	logic signed [eed_pkg::FIELD_W-1:0]  coef_a;
	logic signed [eed_pkg::FIELD_W-1:0]  coef_b;
	logic signed [eed_pkg::FIELD_W-1:0]  rhs_c;

	modport source (output valid, output coef_a, output coef_b, output rhs_c, input ready);
	modport sink (input valid, input coef_a, input coef_b, input rhs_c, output ready);
endinterface

interface eed_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [eed_pkg::SOL_W-1:0]  sol_x;
	logic signed [eed_pkg::SOL_W-1:0]  sol_y;

	modport source (output valid, output sol_x, output sol_y, input ready);
	modport sink (input valid, input sol_x, input sol_y, output ready);
endinterface

// File: rtl/core/eed_euclid.sv
// Shift/subtract extended Euclid datapath: remainders and Bezout coefficients.
`timescale 1ns / 1ps

module eed_euclid #(
	parameter int W = eed_pkg::OPERAND_W_DEF
) (
	input  logic                 clk,
	input  eed_pkg::eed_ctrl_t   ctrl,
	input  logic signed [W-1:0]  op_a,
	input  logic signed [W-1:0]  op_b,
	output eed_pkg::eed_stat_t   stat,
	output logic signed [W+1:0]  coef_x,
	output logic signed [W+1:0]  coef_y
);
	import eed_pkg::*;

	localparam int RW = W + 1;
	localparam int CW = W + 2;
	localparam int KW = $clog2(W + 1);

	logic [RW-1:0]        rp_q, rc_q, d_q;
	logic signed [CW-1:0] sp_q, sc_q, tp_q, tc_q, ds_q, dt_q;
	logic [KW-1:0]        k_q;
	logic                 neg_a_q, neg_b_q;

	logic signed [RW-1:0] a_ext, b_ext;
	logic [RW-1:0]        a_abs, b_abs;
	logic                 a_zero, b_zero;
	logic                 can_align, ge;
	logic [RW-1:0]        r_red;
	logic signed [CW-1:0] s_red, t_red;

	assign a_ext  = RW'(op_a);
	assign b_ext  = RW'(op_b);
	assign a_abs  = a_ext[RW-1] ? RW'(-a_ext) : RW'(a_ext);
	assign b_abs  = b_ext[RW-1] ? RW'(-b_ext) : RW'(b_ext);
	assign a_zero = (op_a == '0);
	assign b_zero = (op_b == '0);

	// the shared unit: an align compare, a reduce compare, one remainder subtract, coefficient subtracts
	assign can_align = ({d_q, 1'b0} <= {1'b0, rp_q});
	assign ge        = (d_q <= rp_q);
	assign r_red     = ge ? RW'(rp_q - d_q) : rp_q;
	assign s_red     = ge ? CW'(sp_q - ds_q) : sp_q;
	assign t_red     = ge ? CW'(tp_q - dt_q) : tp_q;

	assign stat.special   = a_zero || b_zero;
	assign stat.can_align = can_align;
	assign stat.k_zero    = (k_q == '0);
	assign stat.rem_zero  = (r_red == '0);

	assign coef_x = neg_a_q ? CW'(-sp_q) : sp_q;
	assign coef_y = neg_b_q ? CW'(-tp_q) : tp_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			k_q  <= '0;
			rp_q <= a_abs;
			rc_q <= b_abs;
			d_q  <= b_abs;
			sc_q <= '0;
			tc_q <= CW'(1);
			ds_q <= '0;
			dt_q <= CW'(1);
			if (a_zero) begin
				neg_a_q <= 1'b0;
				neg_b_q <= 1'b0;
				sp_q    <= '0;
				tp_q    <= CW'(op_b);
			end else if (b_zero) begin
				neg_a_q <= 1'b0;
				neg_b_q <= 1'b0;
				sp_q    <= CW'(op_a);
				tp_q    <= '0;
			end else begin
				neg_a_q <= op_a[W-1];
				neg_b_q <= op_b[W-1];
				sp_q    <= CW'(1);
				tp_q    <= '0;
			end
		end else if (ctrl.align) begin
			if (can_align) begin
				d_q  <= {d_q[RW-2:0], 1'b0};
				ds_q <= ds_q <<< 1;
				dt_q <= dt_q <<< 1;
				k_q  <= k_q + 1'b1;
			end
		end else if (ctrl.reduce) begin
			if (k_q == '0) begin
				// last quotient bit: rotate rows
				rp_q <= rc_q;
				rc_q <= r_red;
				d_q  <= r_red;
				sp_q <= sc_q;
				sc_q <= s_red;
				ds_q <= s_red;
				tp_q <= tc_q;
				tc_q <= t_red;
				dt_q <= t_red;
			end else begin
				rp_q <= r_red;
				sp_q <= s_red;
				tp_q <= t_red;
				d_q  <= d_q >> 1;
				ds_q <= ds_q >>> 1;
				dt_q <= dt_q >>> 1;
				k_q  <= k_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/eed_scale.sv
// Shared multiplier that scales the coefficient pair by c, and the result register.
`timescale 1ns / 1ps

module eed_scale #(
	parameter int W = eed_pkg::OPERAND_W_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  eed_pkg::eed_mul_ctrl_t  ctrl,
	input  logic signed [W+1:0]     coef_x,
	input  logic signed [W+1:0]     coef_y,
	input  logic signed [W-1:0]     rhs,
	output logic                    out_free,
	eed_rsp_if.source               rsp
);
	import eed_pkg::*;

	localparam int CW = W + 2;
	localparam int PW = CW + W;

	logic signed [CW-1:0]    mul_op;
	logic signed [PW-1:0]    prod;
	logic signed [SOL_W-1:0] px_q;
	logic signed [SOL_W-1:0] sol_x_q, sol_y_q;
	logic                    valid_q;

	assign mul_op   = ctrl.mul_x ? coef_x : coef_y;
	assign prod     = PW'(mul_op) * PW'(rhs);
	assign out_free = !valid_q || rsp.ready;

	assign rsp.valid = valid_q;
	assign rsp.sol_x = sol_x_q;
	assign rsp.sol_y = sol_y_q;

	always_ff @(posedge clk) begin
		if (ctrl.mul_x) begin
			px_q <= SOL_W'(prod);
		end
		if (ctrl.commit) begin
			sol_x_q <= px_q;
			sol_y_q <= SOL_W'(prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.commit) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/core/extended_euclid_diophantine.sv
// Top level of the extended Euclid Diophantine solver: sequencer and datapath units.
`timescale 1ns / 1ps
//
//  channel | dir | beat payload                   | handshake
//  --------+-----+--------------------------------+-------------------
//  req     | in  | coef_a, coef_b, rhs_c (32b)    | valid/ready
//  rsp     | out | sol_x, sol_y (64b signed)      | valid/ready
//
// Each quotient step of a request shifts the divisor up one bit per cycle,
// then subtracts and shifts down one bit per cycle through the single
// compare/subtract unit; the multiply states MUL_X and MUL_Y at the end
// share one multiplier for x*c and y*c. A zero operand skips the
// recurrence and goes straight to the multiply states.
// Reset clears the sequencer and the result valid flag only.
// req is ready only in idle; the result register lets a new request in while
// the last result waits, and the final multiply cycle holds until it drains.

module extended_euclid_diophantine #(
	parameter int OPERAND_WIDTH = eed_pkg::OPERAND_W_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	eed_req_if.sink   req,
	eed_rsp_if.source rsp
);
	import eed_pkg::*;

	localparam int CW = OPERAND_WIDTH + 2;

	eed_state_t    state_q, state_d;
	eed_ctrl_t     ctrl;
	eed_stat_t     stat;
	eed_mul_ctrl_t mul_ctrl;
	logic          out_free;

	logic signed [OPERAND_WIDTH-1:0] op_a, op_b;
	logic signed [OPERAND_WIDTH-1:0] rhs_q;
	logic signed [CW-1:0]            coef_x, coef_y;

	// only the low operand bits count, taken as signed
	assign op_a = $signed(req.coef_a[OPERAND_WIDTH-1:0]);
	assign op_b = $signed(req.coef_b[OPERAND_WIDTH-1:0]);

	assign req.ready = (state_q == ST_IDLE);

	// hold c for the scaling cycles
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rhs_q <= $signed(req.rhs_c[OPERAND_WIDTH-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = stat.special ? ST_MUL_X : ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				// walk the divisor up until one more doubling would overshoot
				if (!stat.can_align) begin
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				// at the last quotient bit, a zero remainder ends the recurrence
				if (stat.k_zero) begin
					state_d = stat.rem_zero ? ST_MUL_X : ST_ALIGN;
				end
			end
			ST_MUL_X: begin
				state_d = ST_MUL_Y;
			end
			ST_MUL_Y: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ctrl            = '0;
		mul_ctrl        = '0;
		ctrl.load       = (state_q == ST_IDLE) && req.valid;
		ctrl.align      = (state_q == ST_ALIGN);
		ctrl.reduce     = (state_q == ST_REDUCE);
		mul_ctrl.mul_x  = (state_q == ST_MUL_X);
		mul_ctrl.commit = (state_q == ST_MUL_Y) && out_free;
	end

	eed_euclid #(
		.W (OPERAND_WIDTH)
	) u_euclid (
		.clk    (clk),
		.ctrl   (ctrl),
		.op_a   (op_a),
		.op_b   (op_b),
		.stat   (stat),
		.coef_x (coef_x),
		.coef_y (coef_y)
	);

	eed_scale #(
		.W (OPERAND_WIDTH)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (mul_ctrl),
		.coef_x   (coef_x),
		.coef_y   (coef_y),
		.rhs      (rhs_q),
		.out_free (out_free),
		.rsp      (rsp)
	);

	// an accepted request always starts work
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_ALIGN || state_q == ST_MUL_X))
		else $error("accepted request did not start the solver");

	// the x product is always followed by the y product
	a_mul_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_X) |=> (state_q == ST_MUL_Y))
		else $error("multiply sequence broken");

	// a new result shows up only from the final multiply cycle
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == ST_MUL_Y))
		else $error("result valid raised outside the commit cycle");

endmodule
